// ----- src/encoder_position_tracker_defines.svh -----
// Assertion macros for the encoder position tracker checker.
`ifndef ENCODER_POSITION_TRACKER_DEFINES_SVH
`define ENCODER_POSITION_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define EPT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("encoder position tracker check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define EPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("encoder position tracker check failed");

`endif

// ----- src/ept_pkg.sv -----
// Shared types and constants of the encoder position tracker.
`timescale 1ns / 1ps

package ept_pkg;

	localparam int CNT_W      = 16;
	localparam int CPM_W      = 16;
	localparam int SPAN_W     = 17;
	localparam int SCALE_W    = 20;
	localparam int POS_W      = 32;
	localparam int FUNC_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int PROD_W     = POS_W + SCALE_W;
	localparam int DIV_STEPS  = PROD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam logic [FUNC_W-1:0] FUNC_POLL = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CPM    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd3;

	localparam logic [CPM_W-1:0]   CPM_RESET   = 16'd512;
	localparam logic [SPAN_W-1:0]  SPAN_RESET  = 17'd65536;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd1000;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [CNT_W-1:0]        counter_value;
		logic signed [POS_W-1:0] target_position;
	} sample_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position_scaled;
		logic signed [POS_W-1:0] position_counts;
	} result_t;

endpackage

// ----- src/ept_if.sv -----
// Valid/ready channel interfaces for encoder samples and position results.
`timescale 1ns / 1ps

interface ept_sample_if;
	logic             valid;
	logic             ready;
	ept_pkg::sample_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ept_result_if;
	logic             valid;
	logic             ready;
	ept_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- src/ept_divider.sv -----
// Restoring serial divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module ept_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ept_pkg::PROD_W-1:0]       dividend,
	input  logic [ept_pkg::SCALE_W-1:0]      divisor,
	output logic                             done,
	output logic [ept_pkg::POS_W-1:0]        quotient
);

	logic [ept_pkg::PROD_W-1:0]    dvd_q;
	logic [ept_pkg::SCALE_W-1:0]   dsr_q;
	logic [ept_pkg::SCALE_W-1:0]   rem_q;
	logic [ept_pkg::POS_W-1:0]     quo_q;
	logic [ept_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [ept_pkg::SCALE_W:0] trial;
	logic [ept_pkg::SCALE_W:0] trial_sub;
	logic                      fits;

	assign trial     = {rem_q, dvd_q[ept_pkg::PROD_W-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign fits      = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ept_pkg::DIV_CNT_W'(ept_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ept_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ept_pkg::PROD_W-2:0], 1'b0};
			rem_q <= fits ? trial_sub[ept_pkg::SCALE_W-1:0] : trial[ept_pkg::SCALE_W-1:0];
			quo_q <= {quo_q[ept_pkg::POS_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/encoder_position_tracker.sv -----
// Top level of the encoder position tracker for one encoder axis.
`timescale 1ns / 1ps

// Usage:
// Samples arrive on the sample channel, one transaction per counter reading, with a
// function code: poll, set position then poll, or initialize from the sample.
// Each sample yields one transaction on the result channel with the position in
// counts and in scaled millimeters.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while no sample is in flight, and the block has no guard for it.
// A poll, initialize or unused function code runs the serial divider once, for the
// scaling of the result; a set-position sample runs it twice. The divider retires one
// quotient bit per cycle over a 52-bit dividend.
// The block takes one sample at a time; sample.ready returns in the cycle the
// result is loaded into the output register.
// A result waits in that register while result.ready is low; the next sample is
// accepted meanwhile, and its own result is held back until the register is free.
// Reset clears the counters and the offset and restores the default configuration.

module encoder_position_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	ept_sample_if.sink                         sample,
	ept_result_if.source                       result,
	input  logic                               cfg_we,
	input  logic [ept_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ept_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
	localparam logic [ST_W-1:0] ST_MUL      = 3'd1;
	localparam logic [ST_W-1:0] ST_DIVSTART = 3'd2;
	localparam logic [ST_W-1:0] ST_DIV      = 3'd3;
	localparam logic [ST_W-1:0] ST_APPLY    = 3'd4;
	localparam logic [ST_W-1:0] ST_PREP     = 3'd5;
	localparam logic [ST_W-1:0] ST_OUT      = 3'd6;

	localparam logic PH_SET = 1'b0;
	localparam logic PH_OUT = 1'b1;

	localparam int DW = 20;

	logic [ST_W-1:0]                state_q;
	logic                           phase_q;
	logic [ept_pkg::FUNC_W-1:0]     func_q;
	logic [ept_pkg::CNT_W-1:0]      now_q;
	logic [ept_pkg::CPM_W-1:0]      cpm_q;
	logic [ept_pkg::SPAN_W-1:0]     span_q;
	logic                           inv_q;
	logic [ept_pkg::SCALE_W-1:0]    scale_q;
	logic [ept_pkg::CNT_W-1:0]      last_q;
	logic [ept_pkg::POS_W-1:0]      acc_q;
	logic [ept_pkg::POS_W-1:0]      off_q;
	logic [ept_pkg::POS_W-1:0]      mag_q;
	logic                           neg_q;
	logic [ept_pkg::PROD_W-1:0]     prod_q;
	logic [ept_pkg::POS_W-1:0]      scaled_q;
	logic                           out_valid_q;
	ept_pkg::result_t               out_q;

	logic [ept_pkg::SCALE_W-1:0]    den;
	logic [ept_pkg::SCALE_W-1:0]    mul_op;
	logic                           den_zero;
	logic [ept_pkg::PROD_W-1:0]     dividend;
	logic                           div_done;
	logic [ept_pkg::POS_W-1:0]      quotient;
	logic [ept_pkg::POS_W-1:0]      rounded;
	logic [ept_pkg::POS_W-1:0]      counts;
	logic signed [DW-1:0]           diff_raw;
	logic signed [DW-1:0]           half;
	logic signed [DW-1:0]           span_ext;
	logic signed [DW-1:0]           diff_wrap;
	logic signed [DW-1:0]           diff_dir;
	logic                           load_out;
	logic                           in_take;

	assign den      = (phase_q == PH_OUT) ? {{(ept_pkg::SCALE_W - ept_pkg::CPM_W){1'b0}}, cpm_q}
	                                      : scale_q;
	assign mul_op   = (phase_q == PH_OUT) ? scale_q
	                                      : {{(ept_pkg::SCALE_W - ept_pkg::CPM_W){1'b0}}, cpm_q};
	assign den_zero = (den == '0);
	assign dividend = prod_q + {{(ept_pkg::PROD_W - ept_pkg::SCALE_W){1'b0}}, den >> 1};
	assign rounded  = den_zero ? '0 : (neg_q ? (~quotient + 1'b1) : quotient);
	assign counts   = acc_q + off_q;

	assign diff_raw  = $signed({{(DW - ept_pkg::CNT_W){1'b0}}, now_q})
	                 - $signed({{(DW - ept_pkg::CNT_W){1'b0}}, last_q});
	assign half      = $signed({{(DW - ept_pkg::SPAN_W + 1){1'b0}}, span_q[ept_pkg::SPAN_W-1:1]});
	assign span_ext  = $signed({{(DW - ept_pkg::SPAN_W){1'b0}}, span_q});
	assign diff_wrap = (diff_raw > half) ? (diff_raw - span_ext)
	                 : ((diff_raw < -half) ? (diff_raw + span_ext) : diff_raw);
	assign diff_dir  = inv_q ? -diff_wrap : diff_wrap;

	assign in_take  = sample.valid && (state_q == ST_IDLE);
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	ept_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIVSTART),
		.dividend (dividend),
		.divisor  (den),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q   <= ept_pkg::CPM_RESET;
			span_q  <= ept_pkg::SPAN_RESET;
			inv_q   <= 1'b0;
			scale_q <= ept_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ept_pkg::REG_CPM:    cpm_q   <= cfg_data[ept_pkg::CPM_W-1:0];
				ept_pkg::REG_SPAN:   span_q  <= cfg_data[ept_pkg::SPAN_W-1:0];
				ept_pkg::REG_INVERT: inv_q   <= cfg_data[0];
				ept_pkg::REG_SCALE:  scale_q <= cfg_data[ept_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SET;
			func_q      <= ept_pkg::FUNC_POLL;
			last_q      <= '0;
			acc_q       <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						func_q <= sample.payload.func;
						if (sample.payload.func == ept_pkg::FUNC_SET) begin
							phase_q <= PH_SET;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_MUL:      state_q <= ST_DIVSTART;
				ST_DIVSTART: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						if (phase_q == PH_SET) begin
							off_q   <= rounded - acc_q;
							state_q <= ST_APPLY;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_APPLY: begin
					case (func_q)
						ept_pkg::FUNC_POLL, ept_pkg::FUNC_SET: begin
							last_q <= now_q;
							acc_q  <= acc_q + ept_pkg::POS_W'(diff_dir);
						end
						ept_pkg::FUNC_INIT: begin
							last_q <= now_q;
							acc_q  <= '0;
							off_q  <= '0;
						end
						default: ;
					endcase
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					phase_q <= PH_OUT;
					state_q <= ST_MUL;
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			now_q <= sample.payload.counter_value;
			neg_q <= sample.payload.target_position[ept_pkg::POS_W-1];
			mag_q <= sample.payload.target_position[ept_pkg::POS_W-1]
			         ? (~sample.payload.target_position + 1'b1)
			         : sample.payload.target_position;
		end else if (state_q == ST_PREP) begin
			neg_q <= counts[ept_pkg::POS_W-1];
			mag_q <= counts[ept_pkg::POS_W-1] ? (~counts + 1'b1) : counts;
		end
		if (state_q == ST_MUL) begin
			prod_q <= ept_pkg::PROD_W'(mag_q) * ept_pkg::PROD_W'(mul_op);
		end
		if ((state_q == ST_DIV) && div_done && (phase_q == PH_OUT)) begin
			scaled_q <= rounded;
		end
		if (load_out) begin
			out_q.position_scaled <= scaled_q;
			out_q.position_counts <= counts;
		end
	end

	assign sample.ready   = (state_q == ST_IDLE);
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

endmodule

// ----- src/ept_checker.sv -----
// Port-level checker for the encoder position tracker and its bind.
`timescale 1ns / 1ps
`include "encoder_position_tracker_defines.svh"

module ept_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [ept_pkg::POS_W-1:0]     res_scaled,
	input logic [ept_pkg::POS_W-1:0]     res_counts
);

	`EPT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
	`EPT_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_scaled) && $stable(res_counts))
	`EPT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`EPT_ASSERT_NOW(a_result_while_busy, $rose(res_valid), !$past(in_ready))

endmodule

bind encoder_position_tracker ept_checker u_ept_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample.valid),
	.in_ready   (sample.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_scaled (result.payload.position_scaled),
	.res_counts (result.payload.position_counts)
);
